[sv/cap_pkg.sv]
package cap_pkg;

    localparam int unsigned ARG_LIMIT  = 8;

    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned INDEX_W    = 3;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned ARGS_W     = 4;
    localparam int unsigned POS_W      = 2;
    localparam int unsigned DATA_W     = 40;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = 2;
    localparam int unsigned LEVEL_W    = 3;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;

    typedef enum logic
    {
        KIND_VALUE = 1'b0,
        KIND_END   = 1'b1
    } kind_t;

    typedef struct packed
    {
        kind_t                kind;
        logic [VALUE_W-1:0]   arg_value;
        logic [INDEX_W-1:0]   arg_index;
        logic [COUNT_W-1:0]   arg_count;
        logic                 too_many;
        logic                 last;
    } item_t;

    typedef struct packed
    {
        logic [1:0] num;
        item_t      first;
        item_t      second;
    } push_t;

    function automatic logic [VALUE_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
        logic [VALUE_W-1:0] c32;
        logic [VALUE_W-1:0] d;
        c32 = {{(VALUE_W-CHAR_W){1'b0}}, c};
        if (c >= CH_LA && c <= CH_LF)
        begin
            d = c32 - VALUE_W'(87);
        end
        else if (c >= CH_UA && c <= CH_UF)
        begin
            d = c32 - VALUE_W'(55);
        end
        else
        begin
            // digits and every other byte: c - '0', wrapping
            d = c32 - VALUE_W'(48);
        end
        return d;
    endfunction

endpackage

[sv/cap_parser.sv]
module cap_parser
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [cap_pkg::CHAR_W-1:0]  char_code,
    output cap_pkg::push_t              push
);
    import cap_pkg::*;

    logic                  line_start_reg, line_start_next;
    logic                  after_space_reg, after_space_next;
    logic                  in_arg_reg, in_arg_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  hex_reg, hex_next;
    logic                  neg_reg, neg_next;
    logic [VALUE_W-1:0]    acc_reg, acc_next;
    logic [ARGS_W-1:0]     args_reg, args_next;
    logic                  ovf_reg, ovf_next;

    logic                  start;
    logic [POS_W-1:0]      pos_eff;
    logic                  hex_eff;
    logic                  neg_eff;
    logic [VALUE_W-1:0]    acc_eff;
    logic [VALUE_W-1:0]    acc_fold;
    item_t                 value_item;
    item_t                 end_item;

    assign start   = after_space_reg && !ovf_reg && (args_reg < ARGS_W'(ARG_LIMIT));
    assign pos_eff = start ? '0 : pos_reg;
    assign hex_eff = start ? 1'b0 : hex_reg;
    assign neg_eff = start ? 1'b0 : neg_reg;
    assign acc_eff = start ? '0 : acc_reg;

    assign acc_fold = (hex_eff ? (acc_eff << 4) : ((acc_eff << 3) + (acc_eff << 1)))
                      + digit_value(char_code);

    always_comb
    begin
        value_item           = '0;
        value_item.kind      = KIND_VALUE;
        value_item.arg_value = neg_reg ? (VALUE_W'(0) - acc_reg) : acc_reg;
        value_item.arg_index = INDEX_W'(args_reg - ARGS_W'(1));
        value_item.last      = 1'b1;

        end_item             = '0;
        end_item.kind        = KIND_END;
        end_item.arg_count   = COUNT_W'(args_reg);
        end_item.too_many    = ovf_reg;
        end_item.last        = 1'b1;
    end

    always_comb
    begin
        line_start_next  = line_start_reg;
        after_space_next = after_space_reg;
        in_arg_next      = in_arg_reg;
        pos_next         = pos_reg;
        hex_next         = hex_reg;
        neg_next         = neg_reg;
        acc_next         = acc_reg;
        args_next        = args_reg;
        ovf_next         = ovf_reg;
        push             = '0;

        if (accept)
        begin
            if (line_start_reg)
            begin
                // command word position; CR here ends an empty line
                line_start_next = 1'b0;
                if (char_code == CH_CR)
                begin
                    line_start_next = 1'b1;
                    push.num        = 2'd1;
                    push.first      = end_item;
                end
            end
            else if (char_code == CH_SPACE)
            begin
                if (in_arg_reg)
                begin
                    push.num    = 2'd1;
                    push.first  = value_item;
                    in_arg_next = 1'b0;
                end
                after_space_next = 1'b1;
            end
            else if (char_code == CH_CR)
            begin
                if (in_arg_reg)
                begin
                    push.num        = 2'd2;
                    push.first      = value_item;
                    push.first.last = 1'b0;
                    push.second     = end_item;
                end
                else
                begin
                    push.num   = 2'd1;
                    push.first = end_item;
                end
                line_start_next  = 1'b1;
                after_space_next = 1'b0;
                in_arg_next      = 1'b0;
                pos_next         = '0;
                hex_next         = 1'b0;
                neg_next         = 1'b0;
                acc_next         = '0;
                args_next        = '0;
                ovf_next         = 1'b0;
            end
            else
            begin
                if (after_space_reg)
                begin
                    after_space_next = 1'b0;
                    if (!ovf_reg)
                    begin
                        if (start)
                        begin
                            args_next = args_reg + ARGS_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
                if (in_arg_reg || start)
                begin
                    in_arg_next = 1'b1;
                    hex_next    = hex_eff;
                    neg_next    = neg_eff;
                    acc_next    = acc_eff;
                    if (pos_eff == POS_W'(0) && char_code == CH_MINUS)
                    begin
                        neg_next = 1'b1;
                    end
                    else if (pos_eff == POS_W'(1) && !hex_eff && !neg_eff
                             && acc_eff == '0 && char_code == CH_X)
                    begin
                        hex_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = acc_fold;
                    end
                    pos_next = (pos_eff == POS_W'(2)) ? pos_eff : pos_eff + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_start_reg  <= 1'b1;
            after_space_reg <= 1'b0;
            in_arg_reg      <= 1'b0;
            pos_reg         <= '0;
            hex_reg         <= 1'b0;
            neg_reg         <= 1'b0;
            acc_reg         <= '0;
            args_reg        <= '0;
            ovf_reg         <= 1'b0;
        end
        else
        begin
            line_start_reg  <= line_start_next;
            after_space_reg <= after_space_next;
            in_arg_reg      <= in_arg_next;
            pos_reg         <= pos_next;
            hex_reg         <= hex_next;
            neg_reg         <= neg_next;
            acc_reg         <= acc_next;
            args_reg        <= args_next;
            ovf_reg         <= ovf_next;
        end
    end

endmodule

[sv/cap_out_fifo.sv]
module cap_out_fifo
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cap_pkg::push_t               push,
    output cap_pkg::item_t               head,
    output logic                         head_valid,
    input  logic                         pop,
    output logic [cap_pkg::LEVEL_W-1:0]  level
);
    import cap_pkg::*;

    item_t                mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic                 do_pop;
    logic [PTR_W-1:0]     wr_ptr_plus1;

    assign head_valid   = (level_reg != '0);
    assign head         = mem_reg[rd_ptr_reg];
    assign level        = level_reg;
    assign do_pop       = pop && head_valid;
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.num);
        rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
        level_next  = level_reg + LEVEL_W'(push.num) - LEVEL_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

[sv/command_argument_parser_core.sv]
// A character's result beats are written into the registered output queue as it is accepted.
// One character per cycle while the queue holds at most two beats; ready depends
// only on the output queue fill. A carriage return that closes an argument yields two
// beats, drained one per cycle while m_axis_tready is high, via a 4-entry output queue.
// Reset (rst_n low, async): parser at start of line, queue empty, no output valid.
module command_argument_parser_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [cap_pkg::CHAR_W-1:0]   s_axis_tdata,   // [7:0] char_code
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [cap_pkg::DATA_W-1:0]   m_axis_tdata,   // [31:0] arg_value, [34:32] arg_index,
                                                         // [38:35] arg_count, [39] too_many
    output logic                         m_axis_tuser,   // [0] kind
    output logic                         m_axis_tlast    // last
);
    import cap_pkg::*;

    logic                 in_accept;
    push_t                push;
    item_t                head;
    logic                 head_valid;
    logic [LEVEL_W-1:0]   level;

    assign s_axis_tready = (level <= LEVEL_W'(FIFO_DEPTH - 2));
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    cap_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .char_code (s_axis_tdata),
        .push      (push)
    );

    cap_out_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .head       (head),
        .head_valid (head_valid),
        .pop        (m_axis_tready),
        .level      (level)
    );

    assign m_axis_tvalid = head_valid;
    assign m_axis_tdata  = {head.too_many, head.arg_count, head.arg_index, head.arg_value};
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= LEVEL_W'(FIFO_DEPTH))
        else $error("output queue overfilled");

    a_cr_yields_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_axis_tdata == CH_CR) |=> m_axis_tvalid)
        else $error("carriage return produced no beat");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_END) |-> m_axis_tlast)
        else $error("end-of-line beat without tlast");

    a_value_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_VALUE)
        |-> (head.arg_count == '0 && !head.too_many))
        else $error("value beat carries end-of-line fields");

endmodule

[tb/sv/cap_result_checker.sv]
module cap_result_checker
    import cap_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [CHAR_W-1:0]   s_axis_tdata,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [DATA_W-1:0]   m_axis_tdata,
    input  logic                m_axis_tuser,
    input  logic                m_axis_tlast,
    output int unsigned         mismatches,
    output int unsigned         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // parser state
    logic                line_start;
    logic                after_space;
    logic                in_arg;
    logic [POS_W-1:0]    arg_pos;
    logic                hex_mode;
    logic                negate;
    logic [VALUE_W-1:0]  acc;
    logic [ARGS_W-1:0]   args_seen;
    logic                overflowed;

    item_t               parsed_items[$];

    task automatic new_line();
        line_start  = 1'b1;
        after_space = 1'b0;
        in_arg      = 1'b0;
        arg_pos     = '0;
        hex_mode    = 1'b0;
        negate      = 1'b0;
        acc         = '0;
        args_seen   = '0;
        overflowed  = 1'b0;
    endtask

    function automatic logic [VALUE_W-1:0] char_weight(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] folded;
        folded = c | 8'h20;
        if (folded >= CH_LA && folded <= CH_LF)
        begin
            return VALUE_W'(10) + VALUE_W'(folded - CH_LA);
        end
        return VALUE_W'(c) - VALUE_W'(CH_0);
    endfunction

    function automatic item_t make_item(input kind_t k, input logic [VALUE_W-1:0] v,
                                        input logic [INDEX_W-1:0] idx,
                                        input logic [COUNT_W-1:0] cnt, input logic many);
        item_t it;
        it.kind      = k;
        it.arg_value = v;
        it.arg_index = idx;
        it.arg_count = cnt;
        it.too_many  = many;
        it.last      = 1'b0;
        return it;
    endfunction

    task automatic close_arg(ref item_t produced[$]);
        produced.push_back(make_item(KIND_VALUE, negate ? (VALUE_W'(0) - acc) : acc,
                                     INDEX_W'(args_seen - 1'b1), '0, 1'b0));
        in_arg = 1'b0;
    endtask

    task automatic parse_char(input logic [CHAR_W-1:0] c);
        item_t produced[$];
        if (line_start)
        begin
            line_start = 1'b0;
            if (c == CH_CR)
            begin
                produced.push_back(make_item(KIND_END, '0, '0, '0, 1'b0));
                new_line();
            end
        end
        else if (c == CH_SPACE)
        begin
            if (in_arg)
            begin
                close_arg(produced);
            end
            after_space = 1'b1;
        end
        else if (c == CH_CR)
        begin
            if (in_arg)
            begin
                close_arg(produced);
            end
            produced.push_back(make_item(KIND_END, '0, '0, COUNT_W'(args_seen), overflowed));
            new_line();
        end
        else
        begin
            if (after_space)
            begin
                after_space = 1'b0;
                if (!overflowed)
                begin
                    if (args_seen < ARGS_W'(ARG_LIMIT))
                    begin
                        args_seen = args_seen + 1'b1;
                        in_arg    = 1'b1;
                        arg_pos   = '0;
                        hex_mode  = 1'b0;
                        negate    = 1'b0;
                        acc       = '0;
                    end
                    else
                    begin
                        overflowed = 1'b1;
                    end
                end
            end
            if (in_arg)
            begin
                if (arg_pos == 0 && c == CH_MINUS)
                begin
                    negate = 1'b1;
                end
                else if (arg_pos == 1 && !hex_mode && !negate && acc == 0 && c == CH_X)
                begin
                    hex_mode = 1'b1;
                end
                else
                begin
                    acc = acc * (hex_mode ? VALUE_W'(16) : VALUE_W'(10)) + char_weight(c);
                end
                if (arg_pos < 2)
                begin
                    arg_pos = arg_pos + 1'b1;
                end
            end
        end
        if (produced.size() > 0)
        begin
            produced[produced.size()-1].last = 1'b1;
        end
        foreach (produced[i])
        begin
            parsed_items.push_back(produced[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        new_line();
    end

    always @(posedge clk or negedge rst_n)
    begin
        item_t want;
        if (!rst_n)
        begin
            new_line();
            parsed_items.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (parsed_items.size() == 0)
                begin
                    $error("result beat with nothing pending, tdata %h", m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = parsed_items.pop_front();
                    check_field("kind", VALUE_W'(want.kind), VALUE_W'(m_axis_tuser));
                    check_field("arg_value", want.arg_value, m_axis_tdata[31:0]);
                    check_field("arg_index", VALUE_W'(want.arg_index),
                                VALUE_W'(m_axis_tdata[34:32]));
                    check_field("arg_count", VALUE_W'(want.arg_count),
                                VALUE_W'(m_axis_tdata[38:35]));
                    check_field("too_many", VALUE_W'(want.too_many),
                                VALUE_W'(m_axis_tdata[39]));
                    check_field("last", VALUE_W'(want.last), VALUE_W'(m_axis_tlast));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                parse_char(s_axis_tdata);
            end
        end
        outstanding = parsed_items.size();
    end

endmodule

[tb/sv/tb_command_argument_parser_core.sv]
module tb_command_argument_parser_core;
    timeunit 1ns;
    timeprecision 1ps;
    import cap_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned CHAR_GOAL   = 1500;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [CHAR_W-1:0]   s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [DATA_W-1:0]   m_axis_tdata;
    logic                m_axis_tuser;
    logic                m_axis_tlast;

    int unsigned         chars_sent = 0;
    int unsigned         idle_pct   = 0;
    int unsigned         stall_pct  = 0;
    int unsigned         cycles     = 0;
    int unsigned         mismatches;
    int unsigned         outstanding;

    command_argument_parser_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    cap_result_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_beat(input logic [CHAR_W-1:0] c);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_beat(s[i]);
        end
    endtask

    task automatic send_random_line();
        logic [CHAR_W-1:0] text[$];
        string             digits;
        string             hexch;
        string             mixed;
        int                n_args;
        int                len;
        logic [CHAR_W-1:0] c;
        digits = "0123456789";
        hexch  = "0123456789abcdefABCDEF";
        mixed  = "0x-1aFX";
        if ($urandom_range(9) == 0)
        begin
            // raw noise, any byte
            len = $urandom_range(1, 12);
            repeat (len)
            begin
                text.push_back(CHAR_W'($urandom_range(255)));
            end
        end
        else
        begin
            text.push_back(($urandom_range(19) == 0) ? CH_SPACE
                                                     : CHAR_W'($urandom_range(8'h21, 8'h7E)));
            repeat ($urandom_range(3))
            begin
                text.push_back(CHAR_W'($urandom_range(8'h61, 8'h7A)));
            end
            n_args = ($urandom_range(5) == 0) ? $urandom_range(9, 11) : $urandom_range(8);
            repeat (n_args)
            begin
                repeat ($urandom_range(1, 2))
                begin
                    text.push_back(CH_SPACE);
                end
                case ($urandom_range(5))
                    0, 1:
                    begin
                        if ($urandom_range(1))
                        begin
                            text.push_back(CH_MINUS);
                        end
                        repeat ($urandom_range(1, 11))
                        begin
                            text.push_back(digits[$urandom_range(9)]);
                        end
                    end
                    2, 3:
                    begin
                        text.push_back(CH_0);
                        text.push_back(CH_X);
                        repeat ($urandom_range(1, 9))
                        begin
                            text.push_back(hexch[$urandom_range(hexch.len()-1)]);
                        end
                    end
                    4:
                    begin
                        repeat ($urandom_range(1, 4))
                        begin
                            text.push_back(mixed[$urandom_range(mixed.len()-1)]);
                        end
                    end
                    default:
                    begin
                        repeat ($urandom_range(1, 3))
                        begin
                            c = CHAR_W'($urandom_range(255));
                            if (c == CH_SPACE || c == CH_CR)
                            begin
                                c = 8'hFF;
                            end
                            text.push_back(c);
                        end
                    end
                endcase
            end
            if ($urandom_range(3) == 0)
            begin
                text.push_back(CH_SPACE);
            end
        end
        text.push_back(CH_CR);
        foreach (text[i])
        begin
            send_beat(text[i]);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty line, blank command word, hex/negative/odd arguments, byte extremes
        send_beat(CH_CR);
        send_beat(CH_SPACE);
        send_beat(CH_CR);
        send_text("c 0xAf -12 0x- ");
        send_beat(8'hFF);
        send_beat(8'h00);
        send_beat(CH_CR);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 78; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 78; end
                default: begin idle_pct = 26; stall_pct = 26; end
            endcase
            while (chars_sent < (ph + 1) * CHAR_GOAL / 4)
            begin
                send_random_line();
            end
        end
        s_axis_tvalid <= 1'b0;

        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[sim.f]
sv/cap_pkg.sv
sv/cap_parser.sv
sv/cap_out_fifo.sv
sv/command_argument_parser_core.sv
tb/sv/cap_result_checker.sv
tb/sv/tb_command_argument_parser_core.sv
